// ===== design/vprm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vprm_pkg
// types and constants for the per-vlan packet rate monitor
// ----------------------------------------------------------------------------
package vprm_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam logic [15:0] TYPE_TAGGED = 16'h8100;
  localparam logic [15:0] VID_MASK = 16'h0fff;
  localparam logic [32:0] SPAN_SHORT = 33'd1;
  localparam logic [32:0] SPAN_MID = 33'd30;
  localparam logic [32:0] SPAN_LONG = 33'd300;

  // x / 30 = (x * RECIP_MID) >> 36, x / 300 = ((x >> 2) * RECIP_LONG) >> 36
  localparam logic [31:0] RECIP_MID = 32'h8888_8889;
  localparam logic [29:0] RECIP_LONG = 30'd916259690;

  typedef struct packed {
    logic [15:0] outer_type;
    logic [15:0] tag_control;
    logic [31:0] time_sec;
  } in_item_t;

  typedef struct packed {
    logic [11:0] vlan_id;
    logic        has_short;
    logic [15:0] rate_short;
    logic        has_mid;
    logic [27:0] rate_mid;
    logic        has_long;
    logic [23:0] rate_long;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COUNT,
    ST_REPORT,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step_search;
    logic do_count;
    logic do_check;
    logic rd_entry;
    logic div_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic hit;
    logic any_fire;
    logic empty;
    logic div_done;
    logic last_entry;
  } sts_t;

endpackage

// ===== design/vprm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vprm_datapath
// entry table, window stamps, reciprocal dividers and result register
// ----------------------------------------------------------------------------
module vprm_datapath import vprm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_strobe,
  output out_item_t out_data
);
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [11:0] ids_m [TABLE_DEPTH];
  logic [31:0] cnt_m [TABLE_DEPTH];
  logic [31:0] mks_m [TABLE_DEPTH];
  logic [31:0] mkm_m [TABLE_DEPTH];
  logic [31:0] mkl_m [TABLE_DEPTH];

  in_item_t    item_r;
  logic [CW-1:0] used_r, idx_r;
  logic [31:0] st_s_r, st_m_r, st_l_r;
  logic        fs_r, fm_r, fl_r, hit_r;
  logic [IW-1:0] hit_idx_r;
  logic [31:0] hit_cnt_r;
  logic [11:0] sid_r;
  logic [31:0] scnt_r;
  logic [IW-1:0] sidx_r;
  logic        svld_r;
  logic [11:0] rid_r;
  logic [31:0] rcnt_r, rms_r, rmm_r, rml_r;
  logic [31:0] dm_r, dl_r;
  logic [27:0] qm_r;
  logic [23:0] ql_r;
  logic        dq_r, ddone_r;
  logic        out_strobe_r;
  out_item_t   out_r;
  logic [IW-1:0] idx;
  logic fs, fm, fl;
  logic [63:0] prod_m;
  logic [59:0] prod_l;

  assign idx = idx_r[IW-1:0];
  assign fs = {1'b0, item_r.time_sec} >= ({1'b0, st_s_r} + SPAN_SHORT);
  assign fm = {1'b0, item_r.time_sec} >= ({1'b0, st_m_r} + SPAN_MID);
  assign fl = {1'b0, item_r.time_sec} >= ({1'b0, st_l_r} + SPAN_LONG);
  assign prod_m = {32'd0, dm_r} * {32'd0, RECIP_MID};
  assign prod_l = {30'd0, dl_r[31:2]} * {30'd0, RECIP_LONG};

  assign sts.search_done = hit_r || (!svld_r && (idx_r >= used_r));
  assign sts.hit = hit_r;
  assign sts.any_fire = fs || fm || fl;
  assign sts.empty = (used_r == '0);
  assign sts.div_done = ddone_r;
  assign sts.last_entry = (idx_r + 1'b1 == used_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      st_s_r <= '0;
      st_m_r <= '0;
      st_l_r <= '0;
      out_strobe_r <= 1'b0;
      hit_r <= 1'b0;
      svld_r <= 1'b0;
      idx_r <= '0;
      dq_r <= 1'b0;
      ddone_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
      if (cmd.load) begin
        item_r <= in_data;
        idx_r <= '0;
        hit_r <= 1'b0;
        svld_r <= 1'b0;
      end
      // table read is registered; the compare acts on the registered entry in the next cycle
      if (cmd.step_search && !hit_r) begin
        if (idx_r < used_r) begin
          sid_r <= ids_m[idx];
          scnt_r <= cnt_m[idx];
          sidx_r <= idx;
          svld_r <= 1'b1;
          idx_r <= idx_r + 1'b1;
        end else begin
          svld_r <= 1'b0;
        end
        if (svld_r && sid_r == item_r.tag_control[11:0]) begin
          hit_r <= 1'b1;
          hit_idx_r <= sidx_r;
          hit_cnt_r <= scnt_r;
        end
      end
      if (cmd.do_count) begin
        if (hit_r) begin
          cnt_m[hit_idx_r] <= hit_cnt_r + 32'd1;
        end else if (used_r < CW'(TABLE_DEPTH)) begin
          ids_m[used_r[IW-1:0]] <= item_r.tag_control[11:0];
          cnt_m[used_r[IW-1:0]] <= '0;
          mks_m[used_r[IW-1:0]] <= '0;
          mkm_m[used_r[IW-1:0]] <= '0;
          mkl_m[used_r[IW-1:0]] <= '0;
          used_r <= used_r + 1'b1;
        end
      end
      if (cmd.do_check) begin
        fs_r <= fs;
        fm_r <= fm;
        fl_r <= fl;
        if (fs) st_s_r <= item_r.time_sec;
        if (fm) st_m_r <= item_r.time_sec;
        if (fl) st_l_r <= item_r.time_sec;
        idx_r <= '0;
      end
      if (cmd.rd_entry) begin
        rid_r <= ids_m[idx];
        rcnt_r <= cnt_m[idx];
        rms_r <= mks_m[idx];
        rmm_r <= mkm_m[idx];
        rml_r <= mkl_m[idx];
      end
      if (cmd.div_start) begin
        dm_r <= rcnt_r - rmm_r;
        dl_r <= rcnt_r - rml_r;
        dq_r <= 1'b1;
        ddone_r <= 1'b0;
      end else if (dq_r) begin
        qm_r <= prod_m[63:36];
        ql_r <= prod_l[59:36];
        dq_r <= 1'b0;
        ddone_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_r.vlan_id <= rid_r;
        out_r.has_short <= fs_r;
        out_r.rate_short <= fs_r ? 16'(rcnt_r - rms_r) : '0;
        out_r.has_mid <= fm_r;
        out_r.rate_mid <= fm_r ? qm_r : '0;
        out_r.has_long <= fl_r;
        out_r.rate_long <= fl_r ? ql_r : '0;
        out_r.last <= (idx_r + 1'b1 == used_r);
        if (fs_r) mks_m[idx] <= rcnt_r;
        if (fm_r) mkm_m[idx] <= rcnt_r;
        if (fl_r) mkl_m[idx] <= rcnt_r;
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data = out_r;
endmodule

// ===== design/vprm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vprm_ctrl
// sequencer for lookup, count and report runs
// ----------------------------------------------------------------------------
module vprm_ctrl import vprm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     is_vlan,
  input  sts_t     sts,
  output cmd_t     cmd,
  output logic     busy
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = is_vlan ? ST_SEARCH : ST_COUNT;
        end
      end
      ST_SEARCH: begin
        cmd.step_search = 1'b1;
        if (sts.search_done) begin
          cmd.step_search = 1'b0;
          cmd.do_count = 1'b1;
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd.do_check = 1'b1;
        state_nxt = (sts.any_fire && !sts.empty) ? ST_REPORT : ST_IDLE;
      end
      ST_REPORT: begin
        cmd.rd_entry = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.div_done) begin
          cmd.emit = 1'b1;
          state_nxt = sts.last_entry ? ST_IDLE : ST_REPORT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== design/vlan_packet_rate_monitor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlan_packet_rate_monitor_core
// per-vlan packet counter with 1 s, 30 s and 300 s rate reports
// ----------------------------------------------------------------------------
// channel   ports                          handshake
// input     in_data                        start high, busy low
// result    out_data                       out_strobe, one cycle
//
// an untagged item goes from load straight to the window check; a tagged item
// first runs a registered id lookup that scans the used entries until a hit
// a report run steps through each entry: read, difference, multiply, emit
// synchronous reset clears the fill count and stamps; the table needs no clear
// results cannot be stalled
module vlan_packet_rate_monitor_core import vprm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_strobe,
  output out_item_t out_data
);
  cmd_t cmd;
  sts_t sts;
  logic is_vlan;

  assign is_vlan = (in_data.outer_type == TYPE_TAGGED) &&
                   ((in_data.tag_control & VID_MASK) != 16'd0);

  vprm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .is_vlan(is_vlan),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  vprm_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .sts(sts),
    .out_strobe(out_strobe), .out_data(out_data)
  );
endmodule
